/* hw/rtl/e2c_pkg.sv */
`timescale 1ns / 1ps

package e2c_pkg;

  // pipeline shape
  localparam int unsigned NUM_STAGES  = 13;
  localparam int unsigned LANE_STAGES = 8;

  // field widths
  localparam int unsigned MILLIS_W = 49;
  localparam int unsigned DAY_W    = 22;
  localparam int unsigned TOD_W    = 27;
  localparam int unsigned ERA_W    = 5;
  localparam int unsigned DOE_W    = 18;
  localparam int unsigned YOE_W    = 9;
  localparam int unsigned DOY_W    = 9;
  localparam int unsigned MP_W     = 4;
  localparam int unsigned YEAR_W   = 14;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned DOM_W    = 5;
  localparam int unsigned HOUR_W   = 5;
  localparam int unsigned MINUTE_W = 6;
  localparam int unsigned SECOND_W = 6;
  localparam int unsigned MSEC_W   = 10;

  // valid window, 0000-01-01T00:00:00.000 to 9999-12-31T23:59:59.999
  localparam logic signed [MILLIS_W-1:0] MIN_MILLIS = -49'sd62167219200000;
  localparam logic signed [MILLIS_W-1:0] MAX_MILLIS = 49'sd253402300799999;

  // calendar constants
  localparam int unsigned MS_PER_DAY    = 86400000;
  localparam int unsigned MS_PER_HOUR   = 3600000;
  localparam int unsigned MS_PER_MINUTE = 60000;
  localparam int unsigned MS_PER_SECOND = 1000;
  localparam int unsigned DAY_DIV_ODD   = MS_PER_DAY >> 10;
  localparam int unsigned DAYS_PER_ERA  = 146097;
  localparam int unsigned YEARS_PER_ERA = 400;
  localparam int unsigned DAYS_PER_YEAR = 365;
  // one era less the day count from 0000-01-01 to the March-based era origin
  localparam int unsigned ERA_BIAS      = DAYS_PER_ERA - 60;

  // reciprocal of the odd part of a day, floor form, corrected afterwards
  localparam int unsigned DAY_SHIFT = 48;
  localparam logic [31:0] DAY_MUL   = 32'((64'd1 << DAY_SHIFT) / 64'(DAY_DIV_ODD));

  // exact reciprocals, ceil form with 2^shift above max operand times divisor
  localparam int unsigned ERA_SHIFT = 40;
  localparam logic [22:0] ERA_MUL   =
    23'(((64'd1 << ERA_SHIFT) + 64'(DAYS_PER_ERA) - 64'd1) / 64'(DAYS_PER_ERA));
  localparam int unsigned Q1460_SHIFT = 28;
  localparam logic [17:0] Q1460_MUL   =
    18'(((64'd1 << Q1460_SHIFT) + 64'd1459) / 64'd1460);
  localparam int unsigned Q36524_SHIFT = 33;
  localparam logic [17:0] Q36524_MUL   =
    18'(((64'd1 << Q36524_SHIFT) + 64'd36523) / 64'd36524);
  localparam int unsigned Q365_SHIFT = 26;
  localparam logic [17:0] Q365_MUL   =
    18'(((64'd1 << Q365_SHIFT) + 64'(DAYS_PER_YEAR) - 64'd1) / 64'(DAYS_PER_YEAR));
  localparam int unsigned Q100_SHIFT = 16;
  localparam logic [9:0]  Q100_MUL   = 10'(((64'd1 << Q100_SHIFT) + 64'd99) / 64'd100);
  localparam int unsigned MP_SHIFT = 19;
  localparam logic [11:0] MP_MUL   = 12'(((64'd1 << MP_SHIFT) + 64'd152) / 64'd153);
  localparam int unsigned HOUR_SHIFT = 49;
  localparam logic [27:0] HOUR_MUL   =
    28'(((64'd1 << HOUR_SHIFT) + 64'(MS_PER_HOUR) - 64'd1) / 64'(MS_PER_HOUR));
  localparam int unsigned MIN_SHIFT = 38;
  localparam logic [22:0] MIN_MUL   =
    23'(((64'd1 << MIN_SHIFT) + 64'(MS_PER_MINUTE) - 64'd1) / 64'(MS_PER_MINUTE));
  localparam int unsigned SEC_SHIFT = 26;
  localparam logic [16:0] SEC_MUL   =
    17'(((64'd1 << SEC_SHIFT) + 64'(MS_PER_SECOND) - 64'd1) / 64'(MS_PER_SECOND));

  // first day of each March-based month within the year
  function automatic logic [DOY_W-1:0] month_start(input logic [MP_W-1:0] mp);
    logic [DOY_W-1:0] days;
    case (mp)
      4'd0:    days = 9'd0;
      4'd1:    days = 9'd31;
      4'd2:    days = 9'd61;
      4'd3:    days = 9'd92;
      4'd4:    days = 9'd122;
      4'd5:    days = 9'd153;
      4'd6:    days = 9'd184;
      4'd7:    days = 9'd214;
      4'd8:    days = 9'd245;
      4'd9:    days = 9'd275;
      4'd10:   days = 9'd306;
      4'd11:   days = 9'd337;
      default: days = 9'd0;
    endcase
    return days;
  endfunction

endpackage

/* hw/rtl/e2c_tod_split.sv */
`timescale 1ns / 1ps

module e2c_tod_split import e2c_pkg::*; (
  input  logic                   clk,
  input  logic [LANE_STAGES-1:0] en,
  input  logic [TOD_W-1:0]       tod,
  output logic [HOUR_W-1:0]      hour,
  output logic [MINUTE_W-1:0]    minute,
  output logic [SECOND_W-1:0]    second,
  output logic [MSEC_W-1:0]      millisecond
);

  logic [TOD_W-1:0]    s0_tod;
  logic [HOUR_W-1:0]   s0_hour;
  logic [21:0]         s1_r1;
  logic [HOUR_W-1:0]   s1_hour;
  logic [21:0]         s2_r1;
  logic [HOUR_W-1:0]   s2_hour;
  logic [MINUTE_W-1:0] s2_min;
  logic [15:0]         s3_r2;
  logic [HOUR_W-1:0]   s3_hour;
  logic [MINUTE_W-1:0] s3_min;
  logic [15:0]         s4_r2;
  logic [HOUR_W-1:0]   s4_hour;
  logic [MINUTE_W-1:0] s4_min;
  logic [SECOND_W-1:0] s4_sec;
  logic [HOUR_W-1:0]   s5_hour;
  logic [MINUTE_W-1:0] s5_min;
  logic [SECOND_W-1:0] s5_sec;
  logic [MSEC_W-1:0]   s5_msec;
  logic [HOUR_W-1:0]   s6_hour;
  logic [MINUTE_W-1:0] s6_min;
  logic [SECOND_W-1:0] s6_sec;
  logic [MSEC_W-1:0]   s6_msec;

  logic [54:0] hour_prod;
  logic [21:0] r1_val;
  logic [44:0] min_prod;
  logic [15:0] r2_val;
  logic [32:0] sec_prod;
  logic [MSEC_W-1:0] msec_val;

  // hour by reciprocal
  assign hour_prod = 55'(tod) * 55'(HOUR_MUL);
  // remainder below one hour
  assign r1_val    = 22'(s0_tod - 27'(s0_hour) * 27'(MS_PER_HOUR));
  // minute by reciprocal
  assign min_prod  = 45'(s1_r1) * 45'(MIN_MUL);
  // remainder below one minute
  assign r2_val    = 16'(s2_r1 - 22'(s2_min) * 22'(MS_PER_MINUTE));
  // second by reciprocal
  assign sec_prod  = 33'(s3_r2) * 33'(SEC_MUL);
  // millisecond remainder
  assign msec_val  = 10'(s4_r2 - 16'(s4_sec) * 16'(MS_PER_SECOND));

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_tod  <= tod;
      s0_hour <= hour_prod[HOUR_SHIFT+HOUR_W-1:HOUR_SHIFT];
    end
    if (en[1]) begin
      s1_r1   <= r1_val;
      s1_hour <= s0_hour;
    end
    if (en[2]) begin
      s2_r1   <= s1_r1;
      s2_hour <= s1_hour;
      s2_min  <= min_prod[MIN_SHIFT+MINUTE_W-1:MIN_SHIFT];
    end
    if (en[3]) begin
      s3_r2   <= r2_val;
      s3_hour <= s2_hour;
      s3_min  <= s2_min;
    end
    if (en[4]) begin
      s4_r2   <= s3_r2;
      s4_hour <= s3_hour;
      s4_min  <= s3_min;
      s4_sec  <= sec_prod[SEC_SHIFT+SECOND_W-1:SEC_SHIFT];
    end
    if (en[5]) begin
      s5_hour <= s4_hour;
      s5_min  <= s4_min;
      s5_sec  <= s4_sec;
      s5_msec <= msec_val;
    end
    // delay to line up with the date lane
    if (en[6]) begin
      s6_hour <= s5_hour;
      s6_min  <= s5_min;
      s6_sec  <= s5_sec;
      s6_msec <= s5_msec;
    end
    if (en[7]) begin
      hour        <= s6_hour;
      minute      <= s6_min;
      second      <= s6_sec;
      millisecond <= s6_msec;
    end
  end

endmodule

/* hw/rtl/e2c_civil.sv */
`timescale 1ns / 1ps

module e2c_civil import e2c_pkg::*; (
  input  logic                   clk,
  input  logic [LANE_STAGES-1:0] en,
  input  logic [DAY_W-1:0]       z,
  output logic [ERA_W-1:0]       era,
  output logic [YOE_W-1:0]       yoe,
  output logic [DOY_W-1:0]       doy,
  output logic [MP_W-1:0]        mp
);

  logic [DAY_W-1:0] s0_z;
  logic [ERA_W-1:0] s0_era, s1_era, s2_era, s3_era, s4_era, s5_era, s6_era;
  logic [DOE_W-1:0] s1_doe, s2_doe, s3_doe, s4_doe, s5_doe;
  logic [6:0]       s2_a;
  logic [2:0]       s2_b;
  logic             s2_c;
  logic [DOE_W-1:0] s3_t;
  logic [YOE_W-1:0] s4_yoe, s5_yoe, s6_yoe;
  logic [1:0]       s5_y100;
  logic [17:0]      s5_yoe365;
  logic [DOY_W-1:0] s6_doy;

  logic [44:0]      era_prod;
  logic [DOE_W-1:0] doe_val;
  logic [35:0]      p1460;
  logic [35:0]      p36524;
  logic [DOE_W-1:0] t_val;
  logic [35:0]      p365;
  logic [18:0]      p100;
  logic [DOY_W-1:0] doy_val;
  logic [10:0]      mp_num;
  logic [22:0]      mp_prod;

  // era of the shifted day count
  assign era_prod = 45'(z) * 45'(ERA_MUL);
  // day within era
  assign doe_val  = 18'(s0_z - 22'(s0_era) * 22'(DAYS_PER_ERA));
  // leap corrections within the era
  assign p1460    = 36'(s1_doe) * 36'(Q1460_MUL);
  assign p36524   = 36'(s1_doe) * 36'(Q36524_MUL);
  assign t_val    = 18'(s2_doe - 18'(s2_a) + 18'(s2_b) - 18'(s2_c));
  // year within era
  assign p365     = 36'(s3_t) * 36'(Q365_MUL);
  assign p100     = 19'(s4_yoe) * 19'(Q100_MUL);
  // day within March-based year
  assign doy_val  = 9'(s5_doe - (s5_yoe365 + 18'(s5_yoe[YOE_W-1:2]) - 18'(s5_y100)));
  // March-based month
  assign mp_num   = 11'(11'(s6_doy) * 11'd5 + 11'd2);
  assign mp_prod  = 23'(mp_num) * 23'(MP_MUL);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_z   <= z;
      s0_era <= era_prod[ERA_SHIFT+ERA_W-1:ERA_SHIFT];
    end
    if (en[1]) begin
      s1_doe <= doe_val;
      s1_era <= s0_era;
    end
    if (en[2]) begin
      s2_doe <= s1_doe;
      s2_era <= s1_era;
      s2_a   <= p1460[Q1460_SHIFT+6:Q1460_SHIFT];
      s2_b   <= p36524[Q36524_SHIFT+2:Q36524_SHIFT];
      s2_c   <= (s1_doe == 18'(DAYS_PER_ERA - 1));
    end
    if (en[3]) begin
      s3_t   <= t_val;
      s3_doe <= s2_doe;
      s3_era <= s2_era;
    end
    if (en[4]) begin
      s4_yoe <= p365[Q365_SHIFT+YOE_W-1:Q365_SHIFT];
      s4_doe <= s3_doe;
      s4_era <= s3_era;
    end
    if (en[5]) begin
      s5_y100   <= p100[Q100_SHIFT+1:Q100_SHIFT];
      s5_yoe365 <= 18'(s4_yoe) * 18'(DAYS_PER_YEAR);
      s5_yoe    <= s4_yoe;
      s5_doe    <= s4_doe;
      s5_era    <= s4_era;
    end
    if (en[6]) begin
      s6_doy <= doy_val;
      s6_yoe <= s5_yoe;
      s6_era <= s5_era;
    end
    if (en[7]) begin
      mp  <= mp_prod[MP_SHIFT+MP_W-1:MP_SHIFT];
      doy <= s6_doy;
      yoe <= s6_yoe;
      era <= s6_era;
    end
  end

endmodule

/* hw/rtl/epoch_ms_to_utc_calendar.sv */
`timescale 1ns / 1ps

// channel   | signals                                   | direction
// ----------+-------------------------------------------+----------
// request   | epoch_valid, epoch_ready, epoch_millis    | in
// result    | date_valid, date_ready, year .. out_of_range | out
//
// one request per cycle while the result side is not stalled, 13 register
// stages; the depth is set by the chain of reciprocal multiplies for day
// split and calendar.
// rst clears only the stage valid bits; payload registers are not reset.
// each stage holds while the stage after it is full and stalled, and
// empty stages fill from upstream, so a stall drops or repeats nothing.

module epoch_ms_to_utc_calendar import e2c_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       epoch_valid,
  output logic                       epoch_ready,
  input  logic signed [MILLIS_W-1:0] epoch_millis,
  output logic                       date_valid,
  input  logic                       date_ready,
  output logic [YEAR_W-1:0]          year,
  output logic [MONTH_W-1:0]         month,
  output logic [DOM_W-1:0]           day_of_month,
  output logic [HOUR_W-1:0]          hour,
  output logic [MINUTE_W-1:0]        minute,
  output logic [SECOND_W-1:0]        second,
  output logic [MSEC_W-1:0]          millisecond,
  output logic                       out_of_range
);

  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES-1:0] vld_in;
  logic [NUM_STAGES:0]   rdy;
  logic [NUM_STAGES-1:0] en;

  logic [NUM_STAGES-2:0] oor;
  logic [MILLIS_W-1:0]   s1_u;
  logic [DAY_W-1:0]      s2_q;
  logic [38:0]           s2_x;
  logic [9:0]            s2_low;
  logic [17:0]           s3_rem;
  logic [DAY_W-1:0]      s3_q;
  logic [9:0]            s3_low;
  logic [DAY_W-1:0]      s4_z;
  logic [TOD_W-1:0]      s4_tod;

  logic                  oor_val;
  logic [MILLIS_W-1:0]   u_val;
  logic [63:0]           day_prod;
  logic [38:0]           rem_full;
  logic                  rem_fix;
  logic [DAY_W-1:0]      dnum;
  logic [16:0]           rem_odd;

  logic [ERA_W-1:0]      c_era;
  logic [YOE_W-1:0]      c_yoe;
  logic [DOY_W-1:0]      c_doy;
  logic [MP_W-1:0]       c_mp;
  logic [HOUR_W-1:0]     t_hour;
  logic [MINUTE_W-1:0]   t_min;
  logic [SECOND_W-1:0]   t_sec;
  logic [MSEC_W-1:0]     t_msec;

  logic                  jan_feb;
  logic [MONTH_W-1:0]    mon_val;
  logic [DOM_W-1:0]      dom_val;
  logic [YEAR_W-1:0]     year_val;

  // stage advance: a stage loads when empty or when its successor moves
  assign rdy[NUM_STAGES] = date_ready;
  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_rdy
    assign rdy[k] = !vld[k] || rdy[k+1];
  end
  assign en          = rdy[NUM_STAGES-1:0];
  assign vld_in      = {vld[NUM_STAGES-2:0], epoch_valid};
  assign epoch_ready = rdy[0];
  assign date_valid  = vld[NUM_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < NUM_STAGES; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld_in[k];
        end
      end
    end
  end

  // range check and shift to a count from 0000-01-01
  assign oor_val = (epoch_millis < MIN_MILLIS) || (epoch_millis > MAX_MILLIS);
  assign u_val   = MILLIS_W'($unsigned(epoch_millis) - $unsigned(MIN_MILLIS));

  // day estimate from the odd part of a day length, may be one short
  assign day_prod = 64'(s1_u[MILLIS_W-1:17]) * 64'(DAY_MUL);

  // remainder against the estimate
  assign rem_full = 39'(s2_x - 39'(s2_q) * 39'(DAY_DIV_ODD));

  // one correction step, then rebuild time of day
  assign rem_fix = (s3_rem >= 18'(DAY_DIV_ODD));
  assign dnum    = s3_q + DAY_W'(rem_fix);
  assign rem_odd = rem_fix ? 17'(s3_rem - 18'(DAY_DIV_ODD)) : 17'(s3_rem);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_u   <= u_val;
      oor[0] <= oor_val;
    end
    if (en[1]) begin
      s2_q   <= day_prod[DAY_SHIFT-7+DAY_W-1:DAY_SHIFT-7];
      s2_x   <= s1_u[MILLIS_W-1:10];
      s2_low <= s1_u[9:0];
    end
    if (en[2]) begin
      s3_rem <= rem_full[17:0];
      s3_q   <= s2_q;
      s3_low <= s2_low;
    end
    if (en[3]) begin
      s4_z   <= DAY_W'(dnum + DAY_W'(ERA_BIAS));
      s4_tod <= {rem_odd, s3_low};
    end
    for (int k = 1; k < NUM_STAGES - 1; k++) begin
      if (en[k]) begin
        oor[k] <= oor[k-1];
      end
    end
  end

  e2c_civil u_civil (
    .clk (clk),
    .en  (en[NUM_STAGES-2:NUM_STAGES-1-LANE_STAGES]),
    .z   (s4_z),
    .era (c_era),
    .yoe (c_yoe),
    .doy (c_doy),
    .mp  (c_mp)
  );

  e2c_tod_split u_tod (
    .clk         (clk),
    .en          (en[NUM_STAGES-2:NUM_STAGES-1-LANE_STAGES]),
    .tod         (s4_tod),
    .hour        (t_hour),
    .minute      (t_min),
    .second      (t_sec),
    .millisecond (t_msec)
  );

  // month, day and year from the March-based values
  assign jan_feb  = (c_mp >= 4'd10);
  assign mon_val  = jan_feb ? 4'(c_mp - 4'd9) : 4'(c_mp + 4'd3);
  assign dom_val  = 5'(c_doy - month_start(c_mp) + 9'd1);
  assign year_val = 14'(15'(c_yoe) + 15'(c_era) * 15'(YEARS_PER_ERA) + 15'(jan_feb)
                        - 15'(YEARS_PER_ERA));

  // output register, fields zeroed out of range
  always_ff @(posedge clk) begin
    if (en[NUM_STAGES-1]) begin
      out_of_range <= oor[NUM_STAGES-2];
      if (oor[NUM_STAGES-2]) begin
        year         <= '0;
        month        <= '0;
        day_of_month <= '0;
        hour         <= '0;
        minute       <= '0;
        second       <= '0;
        millisecond  <= '0;
      end else begin
        year         <= year_val;
        month        <= mon_val;
        day_of_month <= dom_val;
        hour         <= t_hour;
        minute       <= t_min;
        second       <= t_sec;
        millisecond  <= t_msec;
      end
    end
  end

endmodule
